FILE: sv/atcp_pkg.sv
`default_nettype none

package atcp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned ALT_W    = 7;
   localparam int unsigned SIZE_W   = 10;
   localparam int unsigned DIGIT_W  = 4;

   localparam int unsigned RSP_DEPTH = 2;

   localparam logic [BYTE_W-1:0] CH_A_UPPER = 8'h41;
   localparam logic [BYTE_W-1:0] CH_M_LOWER = 8'h6D;
   localparam logic [BYTE_W-1:0] CH_C_LOWER = 8'h63;
   localparam logic [BYTE_W-1:0] CH_C_UPPER = 8'h43;
   localparam logic [BYTE_W-1:0] CH_S_UPPER = 8'h53;
   localparam logic [BYTE_W-1:0] CH_T_UPPER = 8'h54;
   localparam logic [BYTE_W-1:0] CH_ONE     = 8'h31;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

   localparam logic [KIND_W-1:0] KIND_METRES      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CENTIMETRES = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CIRCLE      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SQUARE      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TRIGGER     = 3'd4;

   localparam logic [ALT_W-1:0]  ALT_MAX  = 7'd99;
   localparam logic [SIZE_W-1:0] SIZE_MAX = 10'd999;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_A,
      PH_AM1,
      PH_AM2,
      PH_AC1,
      PH_AC2,
      PH_C1,
      PH_C2,
      PH_C3,
      PH_S1,
      PH_S2,
      PH_S3,
      PH_T,
      PH_T1B,
      PH_T1C,
      PH_T0B,
      PH_T0C
   } phase_type;

   typedef struct packed {
      logic              message_done;
      logic [KIND_W-1:0] message_kind;
      logic [ALT_W-1:0]  altitude_metres;
      logic [ALT_W-1:0]  altitude_centimetres;
      logic [SIZE_W-1:0] circle_diameter;
      logic [SIZE_W-1:0] square_side;
      logic              run_trigger;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/ascii_telemetry_command_parser_core.sv
`default_nettype none

// ASCII command parser for bytes from a serial receiver. Each byte accepted on
// the req_ channel produces exactly one rsp_ transfer carrying the done flag,
// the message kind and the current altitude, size and trigger values after that
// byte. Parsing is a single state update at the moment of acceptance, so one
// byte per cycle is sustained while req_ready is high; the result is queued at
// acceptance and reaches rsp_ after any earlier results. A two-entry response
// queue lets the block take a new byte while an earlier result still waits for
// rsp_ready; the block stalls req_ready only when both entries are occupied.
module ascii_telemetry_command_parser_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [atcp_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_message_done,
   output logic [atcp_pkg::KIND_W-1:0]        rsp_message_kind,
   output logic [atcp_pkg::ALT_W-1:0]         rsp_altitude_metres,
   output logic [atcp_pkg::ALT_W-1:0]         rsp_altitude_centimetres,
   output logic [atcp_pkg::SIZE_W-1:0]        rsp_circle_diameter,
   output logic [atcp_pkg::SIZE_W-1:0]        rsp_square_side,
   output logic                               rsp_run_trigger
);
   import atcp_pkg::*;

   logic       accept;
   logic       queue_full;
   result_type parse_result;
   result_type head;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   atcp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .rx_byte (req_rx_byte),
      .result  (parse_result)
   );

   atcp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (parse_result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_message_done         = head.message_done;
   assign rsp_message_kind         = head.message_kind;
   assign rsp_altitude_metres      = head.altitude_metres;
   assign rsp_altitude_centimetres = head.altitude_centimetres;
   assign rsp_circle_diameter      = head.circle_diameter;
   assign rsp_square_side          = head.square_side;
   assign rsp_run_trigger          = head.run_trigger;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted byte produced no response");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done |-> rsp_message_kind <= KIND_TRIGGER)
      else $error("response kind out of range");

   a_ready_when_draining: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("input stalled after a response transfer");

endmodule

`default_nettype wire

FILE: sv/atcp_parser.sv
`default_nettype none

module atcp_parser (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire logic [atcp_pkg::BYTE_W-1:0]  rx_byte,
   output atcp_pkg::result_type              result
);
   import atcp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [ALT_W-1:0]  metres_ff, metres_in;
   logic [ALT_W-1:0]  centi_ff, centi_in;
   logic [SIZE_W-1:0] circle_ff, circle_in;
   logic [SIZE_W-1:0] square_ff, square_in;
   logic              trigger_ff, trigger_in;

   logic               is_digit;
   logic [DIGIT_W-1:0] digit;
   logic [ALT_W-1:0]   digit_alt;
   logic [ALT_W-1:0]   digit_alt_x10;
   logic [SIZE_W-1:0]  digit_size;
   logic [SIZE_W-1:0]  digit_size_x10;
   logic [SIZE_W-1:0]  digit_size_x100;
   logic               done;
   logic [KIND_W-1:0]  kind;

   assign is_digit        = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign digit           = rx_byte[DIGIT_W-1:0];
   assign digit_alt       = {{(ALT_W-DIGIT_W){1'b0}}, digit};
   assign digit_alt_x10   = (digit_alt << 3) + (digit_alt << 1);
   assign digit_size      = {{(SIZE_W-DIGIT_W){1'b0}}, digit};
   assign digit_size_x10  = (digit_size << 3) + (digit_size << 1);
   assign digit_size_x100 = (digit_size << 6) + (digit_size << 5) + (digit_size << 2);

   always_comb begin
      phase_in   = PH_IDLE;
      metres_in  = metres_ff;
      centi_in   = centi_ff;
      circle_in  = circle_ff;
      square_in  = square_ff;
      trigger_in = trigger_ff;
      done       = 1'b0;
      kind       = KIND_METRES;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == CH_A_UPPER) phase_in = PH_A;
            else if (rx_byte == CH_C_UPPER) phase_in = PH_C1;
            else if (rx_byte == CH_S_UPPER) phase_in = PH_S1;
            else if (rx_byte == CH_T_UPPER) phase_in = PH_T;
         end
         PH_A: begin
            if (rx_byte == CH_M_LOWER) phase_in = PH_AM1;
            else if (rx_byte == CH_C_LOWER) phase_in = PH_AC1;
         end
         PH_AM1: begin
            if (is_digit) begin
               metres_in = digit_alt_x10;
               phase_in  = PH_AM2;
            end
         end
         PH_AM2: begin
            if (is_digit) begin
               metres_in = metres_ff + digit_alt;
               done      = 1'b1;
               kind      = KIND_METRES;
            end
         end
         PH_AC1: begin
            if (is_digit) begin
               centi_in = digit_alt_x10;
               phase_in = PH_AC2;
            end
         end
         PH_AC2: begin
            if (is_digit) begin
               centi_in = centi_ff + digit_alt;
               done     = 1'b1;
               kind     = KIND_CENTIMETRES;
            end
         end
         PH_C1: begin
            if (is_digit) begin
               circle_in = digit_size_x100;
               phase_in  = PH_C2;
            end
         end
         PH_C2: begin
            if (is_digit) begin
               circle_in = circle_ff + digit_size_x10;
               phase_in  = PH_C3;
            end
         end
         PH_C3: begin
            if (is_digit) begin
               circle_in = circle_ff + digit_size;
               done      = 1'b1;
               kind      = KIND_CIRCLE;
            end
         end
         PH_S1: begin
            if (is_digit) begin
               square_in = digit_size_x100;
               phase_in  = PH_S2;
            end
         end
         PH_S2: begin
            if (is_digit) begin
               square_in = square_ff + digit_size_x10;
               phase_in  = PH_S3;
            end
         end
         PH_S3: begin
            if (is_digit) begin
               square_in = square_ff + digit_size;
               done      = 1'b1;
               kind      = KIND_SQUARE;
            end
         end
         PH_T: begin
            if (rx_byte == CH_ONE) phase_in = PH_T1B;
            else if (rx_byte == CH_ZERO) phase_in = PH_T0B;
         end
         PH_T1B: begin
            if (rx_byte == CH_ONE) phase_in = PH_T1C;
         end
         PH_T1C: begin
            if (rx_byte == CH_ONE) begin
               trigger_in = 1'b1;
               done       = 1'b1;
               kind       = KIND_TRIGGER;
            end
         end
         PH_T0B: begin
            if (rx_byte == CH_ZERO) phase_in = PH_T0C;
         end
         PH_T0C: begin
            if (rx_byte == CH_ZERO) begin
               trigger_in = 1'b0;
               done       = 1'b1;
               kind       = KIND_TRIGGER;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         metres_ff  <= '0;
         centi_ff   <= '0;
         circle_ff  <= '0;
         square_ff  <= '0;
         trigger_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         metres_ff  <= metres_in;
         centi_ff   <= centi_in;
         circle_ff  <= circle_in;
         square_ff  <= square_in;
         trigger_ff <= trigger_in;
      end
   end

   always_comb begin
      result.message_done         = done;
      result.message_kind         = kind;
      result.altitude_metres      = metres_in;
      result.altitude_centimetres = centi_in;
      result.circle_diameter      = circle_in;
      result.square_side          = square_in;
      result.run_trigger          = trigger_in;
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      step && done |=> phase_ff == PH_IDLE)
      else $error("phase not idle after completed message");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      metres_ff <= ALT_MAX && centi_ff <= ALT_MAX &&
      circle_ff <= SIZE_MAX && square_ff <= SIZE_MAX)
      else $error("value register out of range");

   a_trigger_only_on_done: assert property (@(posedge clock) disable iff (reset)
      step && !done |=> $stable(trigger_ff))
      else $error("trigger changed without a completed message");

   a_kind_zero_idle: assert property (@(posedge clock) disable iff (reset)
      !done |-> kind == KIND_METRES)
      else $error("kind set without done");

endmodule

`default_nettype wire

FILE: sv/atcp_rsp_queue.sv
`default_nettype none

module atcp_rsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire atcp_pkg::result_type push_data,
   output logic                      full,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output atcp_pkg::result_type      out_data
);
   import atcp_pkg::*;

   localparam int unsigned PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);

   result_type           entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pop;

   assign full      = (count_ff == CNT_W'(RSP_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full response queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("response queue count out of range");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(rd_ptr_ff))
      else $error("response head moved without a transfer");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import atcp_pkg::*;

   typedef logic [BYTE_W-1:0] byte_queue_type[$];

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   typedef enum int {
      MSG_METRES,
      MSG_CENTIMETRES,
      MSG_CIRCLE,
      MSG_SQUARE,
      MSG_TRIG_SET,
      MSG_TRIG_CLEAR
   } msg_sel_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx;
      logic              typed;
      result_type        want;
   } stim_row_type;

   localparam int unsigned RANDOM_BYTES_PER_FLOW = 425;
   localparam int unsigned LONG_HOLD_CYCLES = 80;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned DIRECTED_ROWS = 27;

   localparam result_type AFTER_RESET = '0;
   localparam result_type ALL_METRES = '{1'b1, KIND_METRES, 7'd99, 7'd0, 10'd0, 10'd0, 1'b0};
   localparam result_type ALL_CENTI =
      '{1'b1, KIND_CENTIMETRES, 7'd99, 7'd99, 10'd0, 10'd0, 1'b0};
   localparam result_type ALL_CIRCLE =
      '{1'b1, KIND_CIRCLE, 7'd99, 7'd99, 10'd999, 10'd0, 1'b0};
   localparam result_type ALL_SQUARE =
      '{1'b1, KIND_SQUARE, 7'd99, 7'd99, 10'd999, 10'd999, 1'b0};
   localparam result_type ALL_TRIGGER =
      '{1'b1, KIND_TRIGGER, 7'd99, 7'd99, 10'd999, 10'd999, 1'b1};

   // header, digits at their maximum, aborted trigger, partial circle value,
   // broken message whose breaking byte is a header letter
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CH_A_UPPER, 1'b1, AFTER_RESET},
      '{CH_M_LOWER, 1'b0, '0},
      '{CH_NINE, 1'b0, '0},
      '{CH_NINE, 1'b1, ALL_METRES},
      '{CH_A_UPPER, 1'b0, '0},
      '{CH_C_LOWER, 1'b0, '0},
      '{CH_NINE, 1'b0, '0},
      '{CH_NINE, 1'b1, ALL_CENTI},
      '{CH_C_UPPER, 1'b0, '0},
      '{CH_NINE, 1'b0, '0},
      '{CH_NINE, 1'b0, '0},
      '{CH_NINE, 1'b1, ALL_CIRCLE},
      '{CH_S_UPPER, 1'b0, '0},
      '{CH_NINE, 1'b0, '0},
      '{CH_NINE, 1'b0, '0},
      '{CH_NINE, 1'b1, ALL_SQUARE},
      '{CH_T_UPPER, 1'b0, '0},
      '{CH_ONE, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{CH_T_UPPER, 1'b0, '0},
      '{CH_ONE, 1'b0, '0},
      '{CH_ONE, 1'b0, '0},
      '{CH_ONE, 1'b1, ALL_TRIGGER},
      '{CH_C_UPPER, 1'b0, '0},
      '{CH_ZERO + 8'd7, 1'b0, '0},
      '{CH_A_UPPER, 1'b0, '0},
      '{8'hFF, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_message_done;
   logic [KIND_W-1:0] rsp_message_kind;
   logic [ALT_W-1:0] rsp_altitude_metres;
   logic [ALT_W-1:0] rsp_altitude_centimetres;
   logic [SIZE_W-1:0] rsp_circle_diameter;
   logic [SIZE_W-1:0] rsp_square_side;
   logic rsp_run_trigger;

   ascii_telemetry_command_parser_core dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_rx_byte              (req_rx_byte),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_message_done         (rsp_message_done),
      .rsp_message_kind         (rsp_message_kind),
      .rsp_altitude_metres      (rsp_altitude_metres),
      .rsp_altitude_centimetres (rsp_altitude_centimetres),
      .rsp_circle_diameter      (rsp_circle_diameter),
      .rsp_square_side          (rsp_square_side),
      .rsp_run_trigger          (rsp_run_trigger)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // parser shadow state
   phase_type         shadow_phase = PH_IDLE;
   logic [ALT_W-1:0]  shadow_metres = '0;
   logic [ALT_W-1:0]  shadow_centi = '0;
   logic [SIZE_W-1:0] shadow_circle = '0;
   logic [SIZE_W-1:0] shadow_square = '0;
   logic              shadow_trigger = 1'b0;

   result_type pending_results[$];
   logic       cur_typed = 1'b0;
   result_type cur_want = '0;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   logic       hold_request = 1'b0;
   int         mismatches = 0;
   int         bytes_taken = 0;
   int         results_seen = 0;
   int         kind_count[8];

   task parse_byte(input logic [BYTE_W-1:0] rx, output result_type res);
      logic              is_dig;
      logic [DIGIT_W-1:0] d;
      phase_type         nxt;
      is_dig = (rx >= CH_ZERO) && (rx <= CH_NINE);
      d = DIGIT_W'(rx - CH_ZERO);
      nxt = PH_IDLE;
      res = '0;
      case (shadow_phase)
         PH_IDLE: begin
            if (rx == CH_A_UPPER) nxt = PH_A;
            else if (rx == CH_C_UPPER) nxt = PH_C1;
            else if (rx == CH_S_UPPER) nxt = PH_S1;
            else if (rx == CH_T_UPPER) nxt = PH_T;
         end
         PH_A: begin
            if (rx == CH_M_LOWER) nxt = PH_AM1;
            else if (rx == CH_C_LOWER) nxt = PH_AC1;
         end
         PH_AM1: if (is_dig) begin
            shadow_metres = ALT_W'(d) * 7'd10;
            nxt = PH_AM2;
         end
         PH_AM2: if (is_dig) begin
            shadow_metres = shadow_metres + ALT_W'(d);
            res.message_done = 1'b1;
            res.message_kind = KIND_METRES;
         end
         PH_AC1: if (is_dig) begin
            shadow_centi = ALT_W'(d) * 7'd10;
            nxt = PH_AC2;
         end
         PH_AC2: if (is_dig) begin
            shadow_centi = shadow_centi + ALT_W'(d);
            res.message_done = 1'b1;
            res.message_kind = KIND_CENTIMETRES;
         end
         PH_C1: if (is_dig) begin
            shadow_circle = SIZE_W'(d) * 10'd100;
            nxt = PH_C2;
         end
         PH_C2: if (is_dig) begin
            shadow_circle = shadow_circle + SIZE_W'(d) * 10'd10;
            nxt = PH_C3;
         end
         PH_C3: if (is_dig) begin
            shadow_circle = shadow_circle + SIZE_W'(d);
            res.message_done = 1'b1;
            res.message_kind = KIND_CIRCLE;
         end
         PH_S1: if (is_dig) begin
            shadow_square = SIZE_W'(d) * 10'd100;
            nxt = PH_S2;
         end
         PH_S2: if (is_dig) begin
            shadow_square = shadow_square + SIZE_W'(d) * 10'd10;
            nxt = PH_S3;
         end
         PH_S3: if (is_dig) begin
            shadow_square = shadow_square + SIZE_W'(d);
            res.message_done = 1'b1;
            res.message_kind = KIND_SQUARE;
         end
         PH_T: begin
            if (rx == CH_ONE) nxt = PH_T1B;
            else if (rx == CH_ZERO) nxt = PH_T0B;
         end
         PH_T1B: if (rx == CH_ONE) nxt = PH_T1C;
         PH_T1C: if (rx == CH_ONE) begin
            shadow_trigger = 1'b1;
            res.message_done = 1'b1;
            res.message_kind = KIND_TRIGGER;
         end
         PH_T0B: if (rx == CH_ZERO) nxt = PH_T0C;
         PH_T0C: if (rx == CH_ZERO) begin
            shadow_trigger = 1'b0;
            res.message_done = 1'b1;
            res.message_kind = KIND_TRIGGER;
         end
         default: ;
      endcase
      shadow_phase = nxt;
      res.altitude_metres = shadow_metres;
      res.altitude_centimetres = shadow_centi;
      res.circle_diameter = shadow_circle;
      res.square_side = shadow_square;
      res.run_trigger = shadow_trigger;
   endtask

   function automatic string show_result(result_type r);
      return $sformatf("done=%0d kind=%0d m=%0d cm=%0d circle=%0d square=%0d trig=%0d",
                       r.message_done, r.message_kind, r.altitude_metres,
                       r.altitude_centimetres, r.circle_diameter, r.square_side,
                       r.run_trigger);
   endfunction

   function automatic logic [BYTE_W-1:0] any_digit();
      return CH_ZERO + BYTE_W'($urandom_range(9));
   endfunction

   function automatic byte_queue_type build_message(msg_sel_type sel);
      byte_queue_type q;
      case (sel)
         MSG_METRES, MSG_CENTIMETRES: begin
            q.push_back(CH_A_UPPER);
            q.push_back(sel == MSG_METRES ? CH_M_LOWER : CH_C_LOWER);
            repeat (2) q.push_back(any_digit());
         end
         MSG_CIRCLE, MSG_SQUARE: begin
            q.push_back(sel == MSG_CIRCLE ? CH_C_UPPER : CH_S_UPPER);
            repeat (3) q.push_back(any_digit());
         end
         default: begin
            q.push_back(CH_T_UPPER);
            repeat (3) q.push_back(sel == MSG_TRIG_SET ? CH_ONE : CH_ZERO);
         end
      endcase
      return q;
   endfunction

   function automatic logic [BYTE_W-1:0] breaking_byte();
      logic [BYTE_W-1:0] headers [4] = '{CH_A_UPPER, CH_C_UPPER, CH_S_UPPER, CH_T_UPPER};
      if ($urandom_range(1) == 0) return headers[$urandom_range(3)];
      return BYTE_W'($urandom_range(255));
   endfunction

   task send_byte(input logic [BYTE_W-1:0] rx, input logic typed, input result_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_rx_byte = rx;
      cur_typed = typed;
      cur_want = want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : track_transfers
      result_type predicted;
      result_type seen;
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte, predicted);
            pending_results.push_back(cur_typed ? cur_want : predicted);
            bytes_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_message_done, rsp_message_kind, rsp_altitude_metres,
                     rsp_altitude_centimetres, rsp_circle_diameter, rsp_square_side,
                     rsp_run_trigger};
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: %s", show_result(seen));
            end else begin
               want = pending_results.pop_front();
               if (want.message_done) kind_count[want.message_kind]++;
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d mismatch", results_seen);
                     $display("   expected %s", show_result(want));
                     $display("   actual   %s", show_result(seen));
                  end
               end
            end
         end
      end
   end

   // result side, with one long hold so the block backs up into req_ready
   initial begin : result_side
      int  hold_left;
      logic hold_served;
      hold_left = 0;
      hold_served = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (hold_request && !hold_served) begin
            rsp_ready = 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
            hold_served = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
         end
         @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("ascii_telemetry_command_parser_core test failed");
      $finish;
   end

   initial begin : stimulus
      flow_mode_type  flow;
      byte_queue_type msg;
      int             counted;
      int             r;
      int             cut;
      foreach (kind_count[k]) kind_count[k] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

      for (int m = 0; m < 4; m++) begin
         flow = flow_mode_type'(m);
         sender_idle_pct = (flow == FLOW_SENDER_IDLE) ? 70 : (flow == FLOW_BOTH) ? 17 : 0;
         receiver_stall_pct = (flow == FLOW_RECEIVER_STALL) ? 70 :
                              (flow == FLOW_BOTH) ? 17 : 0;
         if (flow == FLOW_FREE) hold_request = 1'b1;
         counted = 0;
         while (counted < RANDOM_BYTES_PER_FLOW) begin
            r = $urandom_range(99);
            if (r < 85) begin
               msg = build_message(msg_sel_type'($urandom_range(MSG_TRIG_CLEAR)));
               if (r >= 70) begin
                  cut = $urandom_range(msg.size() - 1, 1);
                  msg = msg[0:cut-1];
                  msg.push_back(breaking_byte());
               end
               foreach (msg[i]) send_byte(msg[i], 1'b0, '0);
               counted += msg.size();
            end else begin
               send_byte(BYTE_W'($urandom_range(255)), 1'b0, '0);
               counted++;
            end
         end
      end

      req_valid = 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d bytes parsed, %0d results checked under four flow-control mixes",
               bytes_taken, results_seen);
      $display("messages done: metres %0d, centimetres %0d, circle %0d, square %0d, trigger %0d",
               kind_count[KIND_METRES], kind_count[KIND_CENTIMETRES],
               kind_count[KIND_CIRCLE], kind_count[KIND_SQUARE], kind_count[KIND_TRIGGER]);
      if (mismatches == 0) begin
         $display("ascii_telemetry_command_parser_core test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("ascii_telemetry_command_parser_core test failed");
      end
      $finish;
   end

endmodule
